>>> rtl/core/owbm_pkg.sv
// Shared definitions for the 1-Wire bus master: slot timing, phase codes,
// drive and command codes. Depends on nothing; imported by onewire_bus_master.
package owbm_pkg;

   localparam int MAX_BITS = 64;
   localparam int CNT_W    = $clog2(MAX_BITS + 1);
   localparam int IDX_W    = $clog2(MAX_BITS);
   localparam int TICK_W   = 9;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BITS);

   localparam logic [TICK_W-1:0] T_RST_LOW    = TICK_W'(480);
   localparam logic [TICK_W-1:0] T_RST_WAIT   = TICK_W'(70);
   localparam logic [TICK_W-1:0] T_RST_REC    = TICK_W'(410);
   localparam logic [TICK_W-1:0] T_SLOT_START = TICK_W'(6);
   localparam logic [TICK_W-1:0] T_W0_LOW     = TICK_W'(60);
   localparam logic [TICK_W-1:0] T_W0_REL     = TICK_W'(10);
   localparam logic [TICK_W-1:0] T_W1_REL     = TICK_W'(64);
   localparam logic [TICK_W-1:0] T_RD_WAIT    = TICK_W'(9);
   localparam logic [TICK_W-1:0] T_RD_END     = TICK_W'(55);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_RS_LOW  = 4'd1;
   localparam logic [3:0] PH_RS_WAIT = 4'd2;
   localparam logic [3:0] PH_RS_REC  = 4'd3;
   localparam logic [3:0] PH_W_LOW   = 4'd4;
   localparam logic [3:0] PH_W_REL   = 4'd5;
   localparam logic [3:0] PH_R_LOW   = 4'd6;
   localparam logic [3:0] PH_R_WAIT  = 4'd7;
   localparam logic [3:0] PH_R_END   = 4'd8;

   localparam logic [1:0] DRV_REL  = 2'd0;
   localparam logic [1:0] DRV_LOW  = 2'd1;
   localparam logic [1:0] DRV_HIGH = 2'd2;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam int REQ_W = 72;
   localparam int RSP_W = 72;

   typedef logic [RSP_W-1:0] rsp_type;

endpackage

>>> rtl/core/onewire_bus_master.sv
// Top level of the 1-Wire bus master: slot sequencer and output buffering.
// Depends on owbm_pkg for timing constants and phase, drive and command codes.

// The block takes one request per clock cycle while its output buffer has room and
// returns one result for every request. A request carries a command (a
// one-microsecond tick, or the start of a bus reset, write or read) and the sampled
// line level. Each request updates the phase, tick counter and shift registers when
// it is accepted and its result is registered; a two-entry output buffer lets a new
// request be taken while a result still waits, so the sustained rate is one request
// per cycle whenever the result side keeps up. Start commands are honored only while
// idle; ticks advance bus time only while an operation runs.
module onewire_bus_master
   import owbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // line_level [0], tx_bits [64:1], bit_count [71:65]
   input  logic [REQ_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // line_drive [1:0], busy_res [2], done_res [3], status [4], rx_bits [68:5], zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic [3:0]          phase_ff, phase_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   logic [63:0]         tx_ff, tx_in;
   logic [63:0]         rx_ff, rx_in;
   logic                code_ff, code_in;
   logic [1:0]          drive_ff, drive_in;
   logic                power_ff;
   logic                done_in;

   logic                out_valid_ff, skid_valid_ff;
   rsp_type             out_ff, skid_ff;
   rsp_type             rsp_in;

   logic                accept;
   logic                out_take;
   logic [1:0]          cmd;
   logic                level;
   logic [63:0]         tx_bits;
   logic [CNT_W-1:0]    count_sat;
   logic [TICK_W-1:0]   tick_dec;
   logic [CNT_W-1:0]    left_dec;
   logic [1:0]          idle_drive;
   logic [63:0]         tx_shifted;

   assign cmd       = req_tuser;
   assign level     = req_tdata[0];
   assign tx_bits   = req_tdata[64:1];
   assign count_sat = (req_tdata[71:65] > MAX_COUNT) ? MAX_COUNT : req_tdata[71:65];

   assign accept     = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;

   assign tick_dec   = tick_ff - TICK_W'(1);
   assign left_dec   = left_ff - CNT_W'(1);
   assign idle_drive = power_ff ? DRV_HIGH : DRV_REL;
   assign tx_shifted = {1'b0, tx_ff[63:1]};

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      left_in  = left_ff;
      index_in = index_ff;
      tx_in    = tx_ff;
      rx_in    = rx_ff;
      code_in  = code_ff;
      drive_in = drive_ff;
      done_in  = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (cmd == CMD_RESET) begin
            code_in  = 1'b0;
            drive_in = DRV_LOW;
            phase_in = PH_RS_LOW;
            tick_in  = T_RST_LOW;
         end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            code_in  = 1'b0;
            left_in  = count_sat;
            index_in = '0;
            if (cmd == CMD_READ) begin
               rx_in = '0;
            end else begin
               tx_in = tx_bits;
            end
            if (count_sat == '0) begin
               phase_in = PH_IDLE;
               tick_in  = '0;
               drive_in = idle_drive;
               done_in  = 1'b1;
            end else if (cmd == CMD_WRITE) begin
               drive_in = DRV_LOW;
               phase_in = PH_W_LOW;
               tick_in  = tx_bits[0] ? T_SLOT_START : T_W0_LOW;
            end else begin
               drive_in = DRV_LOW;
               phase_in = PH_R_LOW;
               tick_in  = T_SLOT_START;
            end
         end
      end else if (cmd == CMD_TICK) begin
         tick_in = tick_dec;
         if (tick_dec == '0) begin
            case (phase_ff)
               PH_RS_LOW: begin
                  drive_in = DRV_REL;
                  phase_in = PH_RS_WAIT;
                  tick_in  = T_RST_WAIT;
               end
               PH_RS_WAIT: begin
                  code_in  = level;
                  phase_in = PH_RS_REC;
                  tick_in  = T_RST_REC;
               end
               PH_RS_REC: begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  drive_in = idle_drive;
                  done_in  = 1'b1;
               end
               PH_W_LOW: begin
                  drive_in = DRV_REL;
                  phase_in = PH_W_REL;
                  tick_in  = tx_ff[0] ? T_W1_REL : T_W0_REL;
               end
               PH_W_REL: begin
                  tx_in   = tx_shifted;
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     code_in  = 1'b0;
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                     drive_in = idle_drive;
                     done_in  = 1'b1;
                  end else begin
                     index_in = index_ff + IDX_W'(1);
                     drive_in = DRV_LOW;
                     phase_in = PH_W_LOW;
                     tick_in  = tx_shifted[0] ? T_SLOT_START : T_W0_LOW;
                  end
               end
               PH_R_LOW: begin
                  drive_in = DRV_REL;
                  phase_in = PH_R_WAIT;
                  tick_in  = T_RD_WAIT;
               end
               PH_R_WAIT: begin
                  if (level) begin
                     rx_in[index_ff] = 1'b1;
                  end
                  phase_in = PH_R_END;
                  tick_in  = T_RD_END;
               end
               PH_R_END: begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     code_in  = 1'b0;
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                     drive_in = idle_drive;
                     done_in  = 1'b1;
                  end else begin
                     index_in = index_ff + IDX_W'(1);
                     drive_in = DRV_LOW;
                     phase_in = PH_R_LOW;
                     tick_in  = T_SLOT_START;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  drive_in = idle_drive;
               end
            endcase
         end
      end
   end

   assign rsp_in = {3'b000, rx_in, code_in, done_in, (phase_in != PH_IDLE), drive_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         left_ff  <= '0;
         index_ff <= '0;
         tx_ff    <= '0;
         rx_ff    <= '0;
         code_ff  <= 1'b0;
         drive_ff <= DRV_REL;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         left_ff  <= left_in;
         index_ff <= index_in;
         tx_ff    <= tx_in;
         rx_ff    <= rx_in;
         code_ff  <= code_in;
         drive_ff <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         power_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         if (accept) begin
            out_ff <= rsp_in;
         end
      end else if (accept) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_idle_not_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (drive_ff != DRV_LOW))
      else $error("line pulled low while idle");

   a_busy_tick_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (tick_ff != '0))
      else $error("slot timer empty during an operation");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && done_in) |=> (phase_ff == PH_IDLE))
      else $error("operation finished but sequencer not idle");
`endif

endmodule
